[hw/rtl/aluf_pkg.sv]
// Package for the ALU, flags and branch execute block: opcodes, error codes,
// flag bit positions, sequencing constants and the controller/datapath structs.
// Depends on nothing; every other file of the block refers to it by scoped names.
package aluf_pkg;

    localparam int ADDR_BITS = 16;

    localparam int DATA_BITS = 64;
    localparam int MUL_DIGIT = 16;
    localparam int MUL_STEPS = DATA_BITS / MUL_DIGIT;
    localparam int DIV_STEPS = DATA_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [4:0] OP_MOV  = 5'd0;
    localparam logic [4:0] OP_ADD  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_MUL  = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4;
    localparam logic [4:0] OP_MOD  = 5'd5;
    localparam logic [4:0] OP_XOR  = 5'd6;
    localparam logic [4:0] OP_OR   = 5'd7;
    localparam logic [4:0] OP_AND  = 5'd8;
    localparam logic [4:0] OP_LAND = 5'd9;
    localparam logic [4:0] OP_LOR  = 5'd10;
    localparam logic [4:0] OP_LSH  = 5'd11;
    localparam logic [4:0] OP_RSH  = 5'd12;
    localparam logic [4:0] OP_CMP  = 5'd13;
    localparam logic [4:0] OP_TEST = 5'd14;
    localparam logic [4:0] OP_JL   = 5'd15;
    localparam logic [4:0] OP_JLE  = 5'd16;
    localparam logic [4:0] OP_JG   = 5'd17;
    localparam logic [4:0] OP_JGE  = 5'd18;
    localparam logic [4:0] OP_JE   = 5'd19;
    localparam logic [4:0] OP_JNE  = 5'd20;
    localparam logic [4:0] OP_JZ   = 5'd21;
    localparam logic [4:0] OP_JMP  = 5'd22;
    localparam logic [4:0] OP_PNT  = 5'd23;
    localparam logic [4:0] OP_RET  = 5'd24;
    localparam logic [4:0] OP_INC  = 5'd25;
    localparam logic [4:0] OP_DEC  = 5'd26;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LABEL = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;
    localparam logic [1:0] ERR_SHIFT = 2'd3;

    localparam int FLAG_LT = 0;
    localparam int FLAG_LE = 1;
    localparam int FLAG_GT = 2;
    localparam int FLAG_GE = 3;
    localparam int FLAG_EQ = 4;
    localparam int FLAG_NE = 5;
    localparam int FLAG_Z  = 6;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic write;
    } cmd_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic out_free;
    } status_t;

    function automatic logic [DATA_BITS-1:0] mag64(input logic [DATA_BITS-1:0] v);
        mag64 = v[DATA_BITS-1] ? (DATA_BITS'(0) - v) : v;
    endfunction

endpackage

[hw/rtl/aluf_ctrl.sv]
// Sequencing controller of the execute block: accepts an instruction, runs the
// multiply or divide iterations and hands the result to the output register.
// Depends on aluf_pkg for the command/status structs and step counts.
module aluf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aluf_pkg::status_t status,
    output aluf_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    localparam logic [aluf_pkg::CNT_BITS-1:0] MUL_LAST =
        aluf_pkg::CNT_BITS'(aluf_pkg::MUL_STEPS - 1);
    localparam logic [aluf_pkg::CNT_BITS-1:0] DIV_LAST =
        aluf_pkg::CNT_BITS'(aluf_pkg::DIV_STEPS - 1);

    state_t                          state_reg, state_next;
    logic [aluf_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.load     = s_valid && s_ready;
    assign cmd.mul_step = (state_reg == ST_MUL);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.write    = (state_reg == ST_WRITE) && status.out_free;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    priority if (status.is_mul) begin
                        state_next = ST_MUL;
                    end else if (status.is_div) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_MUL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[hw/rtl/aluf_dp.sv]
// Datapath of the execute block: operand registers, shared multiply/divide
// iteration registers, condition flags, result logic and the output register.
// Depends on aluf_pkg for opcodes, error codes, flags and the command structs.
module aluf_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  aluf_pkg::cmd_t       cmd,
    output aluf_pkg::status_t    status,
    input  logic [4:0]           s_op,
    input  logic signed [63:0]   s_left_value,
    input  logic signed [63:0]   s_right_value,
    input  logic [15:0]          s_instr_addr,
    input  logic [15:0]          s_target_addr,
    input  logic                 s_target_valid,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [63:0]   m_write_value,
    output logic                 m_write_enable,
    output logic [15:0]          m_next_addr,
    output logic                 m_print_valid,
    output logic                 m_halt,
    output logic [1:0]           m_error_code
);

    localparam int W = aluf_pkg::DATA_BITS;

    logic [4:0]            op_reg;
    logic [W-1:0]          a_reg, b_reg;
    logic [15:0]           pc_reg, tgt_reg;
    logic                  tvalid_reg;
    logic [W-1:0]          acc_reg, acc_next;
    logic [W-1:0]          q_reg, q_next;
    logic [W-1:0]          mag_reg, mag_next;
    logic [6:0]            flags_reg, flags_next;
    logic                  valid_reg;

    logic [W-1:0]          res_value;
    logic                  res_we, res_pv, res_hl;
    logic [15:0]           res_next;
    logic [1:0]            res_err;

    logic [W+aluf_pkg::MUL_DIGIT-1:0] prod;
    logic [W-1:0]          rem_sh;
    logic [aluf_pkg::ADDR_BITS-1:0] pc_inc;
    logic signed [31:0]    cx, cy;
    logic [2:0]            jidx;
    logic                  take;

    // Status for the controller: classes of the instruction being offered.
    assign status.is_mul   = (s_op == aluf_pkg::OP_MUL);
    assign status.is_div   = ((s_op == aluf_pkg::OP_DIV) || (s_op == aluf_pkg::OP_MOD))
                             && (s_right_value != '0);
    assign status.out_free = !valid_reg || m_ready;

    // One iteration step of the shared multiply or divide unit.
    assign prod   = mag_reg * q_reg[aluf_pkg::MUL_DIGIT-1:0];
    assign rem_sh = {acc_reg[W-2:0], q_reg[W-1]};

    always_comb begin
        acc_next = acc_reg;
        q_next   = q_reg;
        mag_next = mag_reg;
        priority if (cmd.load) begin
            acc_next = '0;
            q_next   = status.is_mul ? s_right_value : aluf_pkg::mag64(s_left_value);
            mag_next = status.is_mul ? s_left_value : aluf_pkg::mag64(s_right_value);
        end else if (cmd.mul_step) begin
            acc_next = acc_reg + prod[W-1:0];
            mag_next = mag_reg << aluf_pkg::MUL_DIGIT;
            q_next   = q_reg >> aluf_pkg::MUL_DIGIT;
        end else if (cmd.div_step) begin
            if (rem_sh >= mag_reg) begin
                acc_next = rem_sh - mag_reg;
                q_next   = {q_reg[W-2:0], 1'b1};
            end else begin
                acc_next = rem_sh;
                q_next   = {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign pc_inc = aluf_pkg::ADDR_BITS'(pc_reg) + 1'b1;
    assign cx     = $signed(a_reg[31:0]);
    assign cy     = $signed(b_reg[31:0]);
    assign jidx   = 3'(op_reg - aluf_pkg::OP_JL);

    always_comb begin
        res_value  = '0;
        res_we     = 1'b0;
        res_pv     = 1'b0;
        res_hl     = 1'b0;
        res_err    = aluf_pkg::ERR_NONE;
        res_next   = 16'(pc_inc);
        flags_next = flags_reg;
        take       = 1'b0;
        unique case (op_reg)
            aluf_pkg::OP_MOV: begin
                res_value = b_reg;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_ADD: begin
                res_value = a_reg + b_reg;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_SUB: begin
                res_value = a_reg - b_reg;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_MUL: begin
                res_value = acc_reg;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_DIV: begin
                if (b_reg == '0) begin
                    res_err = aluf_pkg::ERR_DIV0;
                end else begin
                    res_value = (a_reg[W-1] ^ b_reg[W-1]) ? (W'(0) - q_reg) : q_reg;
                    res_we    = 1'b1;
                end
            end
            aluf_pkg::OP_MOD: begin
                if (b_reg == '0) begin
                    res_err = aluf_pkg::ERR_DIV0;
                end else begin
                    res_value = a_reg[W-1] ? (W'(0) - acc_reg) : acc_reg;
                    res_we    = 1'b1;
                end
            end
            aluf_pkg::OP_XOR: begin
                res_value = a_reg ^ b_reg;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_OR: begin
                res_value = a_reg | b_reg;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_AND: begin
                res_value = a_reg & b_reg;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_LAND: begin
                res_value = W'((a_reg != '0) && (b_reg != '0));
                res_we    = 1'b1;
            end
            aluf_pkg::OP_LOR: begin
                res_value = W'((a_reg != '0) || (b_reg != '0));
                res_we    = 1'b1;
            end
            aluf_pkg::OP_LSH, aluf_pkg::OP_RSH: begin
                if (|b_reg[W-1:6]) begin
                    res_err = aluf_pkg::ERR_SHIFT;
                end else if (op_reg == aluf_pkg::OP_LSH) begin
                    res_value = a_reg << b_reg[5:0];
                    res_we    = 1'b1;
                end else begin
                    res_value = $signed(a_reg) >>> b_reg[5:0];
                    res_we    = 1'b1;
                end
            end
            aluf_pkg::OP_CMP: begin
                flags_next                   = '0;
                flags_next[aluf_pkg::FLAG_LT] = (cx < cy);
                flags_next[aluf_pkg::FLAG_LE] = (cx <= cy);
                flags_next[aluf_pkg::FLAG_GT] = (cx > cy);
                flags_next[aluf_pkg::FLAG_GE] = (cx >= cy);
                flags_next[aluf_pkg::FLAG_EQ] = (cx == cy);
                flags_next[aluf_pkg::FLAG_NE] = (cx != cy);
            end
            aluf_pkg::OP_TEST: begin
                flags_next                  = '0;
                flags_next[aluf_pkg::FLAG_Z] = ((a_reg[31:0] & b_reg[31:0]) == '0);
            end
            aluf_pkg::OP_JL, aluf_pkg::OP_JLE, aluf_pkg::OP_JG, aluf_pkg::OP_JGE,
            aluf_pkg::OP_JE, aluf_pkg::OP_JNE, aluf_pkg::OP_JZ, aluf_pkg::OP_JMP: begin
                take = (op_reg == aluf_pkg::OP_JMP) || flags_reg[jidx];
                if (take) begin
                    if (tvalid_reg) begin
                        res_next = tgt_reg;
                    end else begin
                        res_err = aluf_pkg::ERR_LABEL;
                    end
                end
            end
            aluf_pkg::OP_PNT: begin
                res_value = a_reg;
                res_pv    = 1'b1;
            end
            aluf_pkg::OP_RET: begin
                res_value = a_reg;
                res_hl    = 1'b1;
            end
            aluf_pkg::OP_INC: begin
                res_value = a_reg + 1'b1;
                res_we    = 1'b1;
            end
            aluf_pkg::OP_DEC: begin
                res_value = a_reg - 1'b1;
                res_we    = 1'b1;
            end
            default: begin
                res_value = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        mag_reg <= mag_next;
        if (cmd.load) begin
            op_reg     <= s_op;
            a_reg      <= s_left_value;
            b_reg      <= s_right_value;
            pc_reg     <= s_instr_addr;
            tgt_reg    <= s_target_addr;
            tvalid_reg <= s_target_valid;
        end
        if (cmd.write) begin
            m_write_value  <= res_value;
            m_write_enable <= res_we;
            m_next_addr    <= res_next;
            m_print_valid  <= res_pv;
            m_halt         <= res_hl;
            m_error_code   <= res_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.write) begin
                flags_reg <= flags_next;
            end
            if (cmd.write) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = valid_reg;

endmodule

[hw/rtl/alu_flags_branch_execute.sv]
// Execute stage for one interpreted instruction: ALU, seven condition flags, branch select.
// Mul runs four 16-bit digit steps, div/mod by a nonzero divisor one quotient bit a cycle;
// other opcodes go straight to the result write, which waits while the output register
// holds an untaken result. A new instruction is taken only after the last is written; the
// result register lets the next instruction transfer in while a result still waits.
// Reset: synchronous active-low aresetn clears the flags, the sequencer and the result valid.
module alu_flags_branch_execute (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [4:0]           s_op,
    input  logic signed [63:0]   s_left_value,
    input  logic signed [63:0]   s_right_value,
    input  logic [15:0]          s_instr_addr,
    input  logic [15:0]          s_target_addr,
    input  logic                 s_target_valid,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [63:0]   m_write_value,
    output logic                 m_write_enable,
    output logic [15:0]          m_next_addr,
    output logic                 m_print_valid,
    output logic                 m_halt,
    output logic [1:0]           m_error_code
);

    // The controller only sequences: it decides when operands are captured, how many
    // multiply or divide iterations run, and when the result is written to the output
    // register. All arithmetic, the flags and the output register sit in the datapath.
    aluf_pkg::cmd_t    cmd;
    aluf_pkg::status_t status;

    aluf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath shares one set of iteration registers between the multiplier
    // (a 64x16 digit product accumulated four times) and the restoring divider
    // (one quotient bit per cycle on operand magnitudes, signs fixed at the end).
    aluf_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_op           (s_op),
        .s_left_value   (s_left_value),
        .s_right_value  (s_right_value),
        .s_instr_addr   (s_instr_addr),
        .s_target_addr  (s_target_addr),
        .s_target_valid (s_target_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_value  (m_write_value),
        .m_write_enable (m_write_enable),
        .m_next_addr    (m_next_addr),
        .m_print_valid  (m_print_valid),
        .m_halt         (m_halt),
        .m_error_code   (m_error_code)
    );

    // Only one instruction is in flight: after an input transfer the block must
    // not be ready again in the very next cycle.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an instruction is still executing");

    // A faulted instruction never writes its destination.
    a_error_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error_code != aluf_pkg::ERR_NONE)) |-> !m_write_enable)
        else $error("write enable raised together with an error code");

    // Print, return and register write are mutually exclusive result kinds.
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_write_enable, m_print_valid, m_halt}))
        else $error("more than one result kind flagged");

endmodule
